### rtl/page_table_map_unmap_walker_unit_assert.svh
// Assertion macros for the page table walker unit checker.
// Uses no other file; the checker module includes this header.
`ifndef PAGE_TABLE_MAP_UNMAP_WALKER_UNIT_ASSERT_SVH
`define PAGE_TABLE_MAP_UNMAP_WALKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PTWU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PTWU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ptwu_pkg.sv
// Shared types and constants for the page table walker unit.
// Depends on nothing; the interfaces, walker, top level, checker and testbench use it.
`default_nettype none

package ptwu_pkg;

  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int FLAG_W  = 12;
  localparam int FRAME_W = 40;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;
  localparam int ENTRIES = 512;
  localparam int PAGE_SH = 12;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_UNMAP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_PAGES = 2'd1,
    ST_NO_MAP   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    W_INIT,
    W_IDLE,
    W_READ,
    W_EVAL,
    W_CLEAR,
    W_LEAF,
    W_RESP
  } walk_state_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [VA_W-1:0]        virt_addr;
    logic [PA_W-1:0]        phys_addr;
    logic [FLAG_W-1:0]      flag_bits;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic                   invalidate_valid;
    logic [VA_W-1:0]        invalidate_addr;
  } res_t;

endpackage

`default_nettype wire

### rtl/ptwu_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on ptwu_pkg for field widths.
`default_nettype none

interface ptwu_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [ptwu_pkg::VA_W-1:0]   virt_addr;
  logic [ptwu_pkg::PA_W-1:0]   phys_addr;
  logic [ptwu_pkg::FLAG_W-1:0] flag_bits;

  modport source (output valid, opcode, virt_addr, phys_addr, flag_bits, input ready);
  modport sink (input valid, opcode, virt_addr, phys_addr, flag_bits, output ready);
endinterface

interface ptwu_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic                      invalidate_valid;
  logic [ptwu_pkg::VA_W-1:0] invalidate_addr;

  modport source (output valid, status, invalidate_valid, invalidate_addr, input ready);
  modport sink (input valid, status, invalidate_valid, invalidate_addr, output ready);
endinterface

`default_nettype wire

### rtl/ptwu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ptwu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/ptwu_walk.sv
// Walk sequencer: reads, links, clears and writes table entries in the table RAM.
// Depends on ptwu_pkg; drives one ptwu_ram instance through its ports.
`default_nettype none

module ptwu_walk #(
  parameter int TABLE_PAGES = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 req_valid,
  output logic                                                 req_ready,
  input  ptwu_pkg::req_t                                       req,
  output logic                                                 res_valid,
  input  logic                                                 res_ready,
  output ptwu_pkg::res_t                                       res,
  input  logic [ptwu_pkg::FRAME_W-1:0]                         base_frame,
  output logic                                                 mem_we,
  output logic [$clog2(TABLE_PAGES)+ptwu_pkg::IDX_W-1:0]       mem_waddr,
  output logic [ptwu_pkg::ENTRY_W-1:0]                         mem_wdata,
  output logic                                                 mem_re,
  output logic [$clog2(TABLE_PAGES)+ptwu_pkg::IDX_W-1:0]       mem_raddr,
  input  logic [ptwu_pkg::ENTRY_W-1:0]                         mem_rdata
);
  import ptwu_pkg::*;

  localparam int PW = $clog2(TABLE_PAGES);
  localparam int NW = $clog2(TABLE_PAGES + 1);

  walk_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           lvl_r, lvl_nxt;
  logic [PW-1:0]        page_r, page_nxt;
  logic [NW-1:0]        nfp_r, nfp_nxt;
  req_t                 req_r, req_nxt;
  status_t              status_r, status_nxt;

  logic [IDX_W-1:0]     idx_cur;
  logic                 create;
  logic                 ent_present;
  logic [FRAME_W-1:0]   ent_page;
  logic                 ent_in_store;
  logic                 pages_left;
  logic [FRAME_W-1:0]   link_frame;
  logic [ENTRY_W-1:0]   link_entry;
  logic [ENTRY_W-1:0]   leaf_entry;
  logic                 cnt_last;

  always_comb begin
    unique case (lvl_r)
      2'd0:    idx_cur = req_r.virt_addr[47:39];
      2'd1:    idx_cur = req_r.virt_addr[38:30];
      2'd2:    idx_cur = req_r.virt_addr[29:21];
      default: idx_cur = req_r.virt_addr[20:12];
    endcase
  end

  assign create       = (req_r.opcode == OP_MAP);
  assign ent_present  = mem_rdata[0];
  assign ent_page     = mem_rdata[PA_W-1:PAGE_SH] - base_frame;
  assign ent_in_store = (ent_page < FRAME_W'(TABLE_PAGES));
  assign pages_left   = (nfp_r < NW'(TABLE_PAGES));
  assign link_frame   = base_frame + FRAME_W'(nfp_r);
  assign link_entry   = {12'd0, link_frame, 10'd0, 2'b11};
  assign leaf_entry   = {12'd0, req_r.phys_addr[PA_W-1:PAGE_SH],
                         req_r.flag_bits[FLAG_W-1:1], 1'b1};
  assign cnt_last     = (cnt_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    lvl_nxt    = lvl_r;
    page_nxt   = page_r;
    nfp_nxt    = nfp_r;
    req_nxt    = req_r;
    status_nxt = status_r;
    unique case (state_r)
      W_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = W_IDLE;
        end
      end
      W_IDLE: begin
        if (req_valid) begin
          req_nxt   = req;
          lvl_nxt   = 2'd0;
          page_nxt  = '0;
          state_nxt = W_READ;
        end
      end
      W_READ: begin
        state_nxt = W_EVAL;
      end
      W_EVAL: begin
        priority if (ent_present) begin
          if (ent_in_store) begin
            page_nxt = ent_page[PW-1:0];
            if (lvl_r == 2'd2) begin
              state_nxt = W_LEAF;
            end else begin
              lvl_nxt   = lvl_r + 1'b1;
              state_nxt = W_READ;
            end
          end else begin
            status_nxt = create ? ST_NO_PAGES : ST_NO_MAP;
            state_nxt  = W_RESP;
          end
        end else if (!create) begin
          status_nxt = ST_NO_MAP;
          state_nxt  = W_RESP;
        end else if (!pages_left) begin
          status_nxt = ST_NO_PAGES;
          state_nxt  = W_RESP;
        end else begin
          nfp_nxt   = nfp_r + 1'b1;
          page_nxt  = nfp_r[PW-1:0];
          cnt_nxt   = '0;
          state_nxt = W_CLEAR;
        end
      end
      W_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          if (lvl_r == 2'd2) begin
            state_nxt = W_LEAF;
          end else begin
            lvl_nxt   = lvl_r + 1'b1;
            state_nxt = W_READ;
          end
        end
      end
      W_LEAF: begin
        status_nxt = ST_DONE;
        state_nxt  = W_RESP;
      end
      W_RESP: begin
        if (res_ready) begin
          state_nxt = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_INIT;
      end
    endcase
  end

  always_comb begin
    req_ready = (state_r == W_IDLE);
    res_valid = (state_r == W_RESP);
    mem_re    = (state_r == W_READ);
    mem_raddr = {page_r, idx_cur};
    mem_we    = 1'b0;
    mem_waddr = {page_r, idx_cur};
    mem_wdata = '0;
    unique case (state_r)
      W_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = {PW'(0), cnt_r};
      end
      W_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {page_r, cnt_r};
      end
      W_EVAL: begin
        mem_we    = !ent_present && create && pages_left;
        mem_wdata = link_entry;
      end
      W_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = {page_r, req_r.virt_addr[20:12]};
        mem_wdata = create ? leaf_entry : '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    res.status           = status_r;
    res.invalidate_valid = (status_r == ST_DONE);
    res.invalidate_addr  = (status_r == ST_DONE) ? req_r.virt_addr : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_INIT;
      cnt_r   <= '0;
      nfp_r   <= NW'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nfp_r   <= nfp_nxt;
    end
    lvl_r    <= lvl_nxt;
    page_r   <= page_nxt;
    req_r    <= req_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

### rtl/page_table_map_unmap_walker_unit.sv
// Steps: a map or unmap over present levels runs three read/evaluate pairs, the leaf write and
// the result state before its result reaches the output; each new table is cleared entry by entry.
// Requests are served one at a time over the single table RAM port pair; the next request is taken
// once the previous result sits in the output register.
// Reset: synchronous, active low; then the root table is cleared entry by entry, input not ready.
// Depends on ptwu_pkg, ptwu_ifs, ptwu_ram and ptwu_walk.
`default_nettype none

module page_table_map_unmap_walker_unit #(
  parameter int TABLE_PAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ptwu_req_if.sink                       in_req,
  ptwu_rsp_if.source                     out_rsp,
  input  logic                           cfg_we,
  input  logic [ptwu_pkg::FRAME_W-1:0]   cfg_wdata
);
  import ptwu_pkg::*;

  localparam int DEPTH = TABLE_PAGES * ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  logic [FRAME_W-1:0] base_r;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r;

  req_t               req;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  assign req.opcode    = opcode_t'(in_req.opcode);
  assign req.virt_addr = in_req.virt_addr;
  assign req.phys_addr = in_req.phys_addr;
  assign req.flag_bits = in_req.flag_bits;

  assign res_ready     = !out_valid_r || out_rsp.ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_rsp.ready);

  ptwu_walk #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_req.valid),
    .req_ready  (in_req.ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .base_frame (base_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ptwu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.status           = out_res_r.status;
  assign out_rsp.invalidate_valid = out_res_r.invalidate_valid;
  assign out_rsp.invalidate_addr  = out_res_r.invalidate_addr;

endmodule

`default_nettype wire

### rtl/ptwu_checker.sv
// Port-level checker for the page table walker unit, bound to the top level.
// Depends on ptwu_pkg and page_table_map_unmap_walker_unit_assert.svh.
`default_nettype none
`include "page_table_map_unmap_walker_unit_assert.svh"

module ptwu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_status,
  input logic                      out_inv_valid,
  input logic [ptwu_pkg::VA_W-1:0] out_inv_addr
);
  import ptwu_pkg::*;

  `PTWU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PTWU_ASSERT_NOW(a_inv_done, out_valid && out_inv_valid, out_status == ST_DONE, "flush without done")
  `PTWU_ASSERT_NOW(a_no_inv_addr, out_valid && !out_inv_valid, out_inv_addr == '0, "stray flush address")
  `PTWU_ASSERT_NOW(a_init_busy, $past(!rst_n), !in_ready, "request taken during root clearing")

endmodule

bind page_table_map_unmap_walker_unit ptwu_checker u_ptwu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_status    (out_rsp.status),
  .out_inv_valid (out_rsp.invalidate_valid),
  .out_inv_addr  (out_rsp.invalidate_addr)
);

`default_nettype wire

### tb/sv/page_table_map_unmap_walker_unit_tb.sv
// Testbench for page_table_map_unmap_walker_unit: map and unmap requests go in over
// valid/ready channels, and every result is checked against an in-bench table walk.
// Depends on ptwu_pkg, ptwu_ifs and the unit's RTL.
module page_table_map_unmap_walker_unit_tb;
  import ptwu_pkg::*;

  localparam int PAGES = 16;
  localparam int LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [FRAME_W-1:0] BASE_MAX = '1;
  localparam logic [ENTRY_W-1:0] PRESENT_BIT = 64'h1;
  localparam logic [ENTRY_W-1:0] LINK_BITS = 64'h3;

  class walk_scoreboard;
    bit [ENTRY_W-1:0] table_mem [PAGES*ENTRIES];
    int unsigned next_page;
    bit [FRAME_W-1:0] base_frame;
    res_t expected_q[$];
    int errors;
    int status_seen [3];

    function new();
      foreach (table_mem[i]) table_mem[i] = '0;
      next_page = 1;
      base_frame = '0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_base(bit [FRAME_W-1:0] b);
      base_frame = b;
    endfunction

    // A walk is safe when every table page it reaches has been cleared at some point.
    function bit walk_safe(logic [VA_W-1:0] va);
      int unsigned page;
      bit [ENTRY_W-1:0] e;
      bit [FRAME_W-1:0] rel;
      page = 0;
      for (int l = 0; l < 3; l++) begin
        e = table_mem[page*ENTRIES + va[VA_W-1-IDX_W*l -: IDX_W]];
        if (!e[0]) return 1'b1;
        rel = e[PA_W-1:PAGE_SH] - base_frame;
        if (rel >= PAGES) return 1'b1;
        if (rel >= next_page) return 1'b0;
        page = rel[31:0];
      end
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      res_t x;
      bit make;
      int unsigned page;
      int slot;
      status_t st;
      bit [ENTRY_W-1:0] e;
      bit [FRAME_W-1:0] rel;
      bit [FRAME_W-1:0] fr;
      make = (r.opcode == OP_MAP);
      page = 0;
      st = ST_DONE;
      for (int l = 0; l < 3 && st == ST_DONE; l++) begin
        slot = page*ENTRIES + r.virt_addr[VA_W-1-IDX_W*l -: IDX_W];
        e = table_mem[slot];
        if (e[0]) begin
          rel = e[PA_W-1:PAGE_SH] - base_frame;
          if (rel < PAGES) page = rel[31:0];
          else st = make ? ST_NO_PAGES : ST_NO_MAP;
        end else if (!make) begin
          st = ST_NO_MAP;
        end else if (next_page >= PAGES) begin
          st = ST_NO_PAGES;
        end else begin
          for (int k = 0; k < ENTRIES; k++) table_mem[next_page*ENTRIES + k] = '0;
          fr = base_frame + next_page;
          table_mem[slot] = {{(ENTRY_W-PA_W){1'b0}}, fr, {PAGE_SH{1'b0}}} | LINK_BITS;
          page = next_page;
          next_page++;
        end
      end
      x = '0;
      x.status = st;
      if (st == ST_DONE) begin
        slot = page*ENTRIES + r.virt_addr[PAGE_SH +: IDX_W];
        if (make)
          table_mem[slot] = {{(ENTRY_W-PA_W){1'b0}}, r.phys_addr[PA_W-1:PAGE_SH], r.flag_bits}
                            | PRESENT_BIT;
        else
          table_mem[slot] = '0;
        x.invalidate_valid = 1'b1;
        x.invalidate_addr = r.virt_addr;
      end
      expected_q.push_back(x);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("Mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result status %0d inv %0b addr %h",
                             got.status, got.invalidate_valid, got.invalidate_addr));
        return;
      end
      want = expected_q.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status || got.invalidate_valid !== want.invalidate_valid ||
          got.invalidate_addr !== want.invalidate_addr)
        flag_error($sformatf("expected status %0d inv %0b addr %h, got status %0d inv %0b addr %h",
                             want.status, want.invalidate_valid, want.invalidate_addr,
                             got.status, got.invalidate_valid, got.invalidate_addr));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;

  ptwu_req_if in_req();
  ptwu_rsp_if out_rsp();

  walk_scoreboard sb = new();
  logic [VA_W-1:0] seen_va[$];
  int accepted;
  int base_writes;
  int send_calm;

  page_table_map_unmap_walker_unit #(.TABLE_PAGES(PAGES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req),
    .out_rsp(out_rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every transfer on either channel is seen here, at the rising edge.
  always @(posedge clk) begin
    req_t taken;
    res_t got;
    if (rst_n && in_req.valid && in_req.ready) begin
      taken.opcode = opcode_t'(in_req.opcode);
      taken.virt_addr = in_req.virt_addr;
      taken.phys_addr = in_req.phys_addr;
      taken.flag_bits = in_req.flag_bits;
      sb.note_request(taken);
      seen_va.push_back(in_req.virt_addr);
      accepted++;
    end
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got.status = status_t'(out_rsp.status);
      got.invalidate_valid = out_rsp.invalidate_valid;
      got.invalidate_addr = out_rsp.invalidate_addr;
      sb.check_result(got);
    end
  end

  function automatic req_t mk_req(opcode_t op, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                  logic [FLAG_W-1:0] fl);
    req_t r;
    r.opcode = op;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.flag_bits = fl;
    return r;
  endfunction

  // Mostly reuses all or the upper part of an address already used, so walks run deep into existing tables.
  function automatic req_t make_request();
    req_t r;
    logic [VA_W-1:0] va;
    logic [VA_W-1:0] old_va;
    int pick;
    r.opcode = ($urandom_range(0, 99) < 55) ? OP_MAP : OP_UNMAP;
    r.phys_addr = PA_W'({$urandom(), $urandom()});
    r.flag_bits = FLAG_W'($urandom());
    va = VA_W'({$urandom(), $urandom()});
    if (seen_va.size() != 0) begin
      old_va = seen_va[$urandom_range(0, seen_va.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 40) va = old_va;
      else if (pick < 65) va[VA_W-1:PAGE_SH+IDX_W] = old_va[VA_W-1:PAGE_SH+IDX_W];
      else if (pick < 80) va[VA_W-1:PAGE_SH+2*IDX_W] = old_va[VA_W-1:PAGE_SH+2*IDX_W];
      else if (pick < 90) va[VA_W-1:PAGE_SH+3*IDX_W] = old_va[VA_W-1:PAGE_SH+3*IDX_W];
    end
    r.virt_addr = va;
    return r;
  endfunction

  task automatic send_item(input req_t r, input bit fresh);
    int tries;
    @(negedge clk);
    if (fresh) begin
      tries = 0;
      do begin
        r = make_request();
        tries++;
      end while (!sb.walk_safe(r.virt_addr) && tries < 20);
    end
    while (!sb.walk_safe(r.virt_addr)) r.virt_addr[VA_W-1 -: IDX_W] = IDX_W'($urandom());
    in_req.valid <= 1'b1;
    in_req.opcode <= r.opcode;
    in_req.virt_addr <= r.virt_addr;
    in_req.phys_addr <= r.phys_addr;
    in_req.flag_bits <= r.flag_bits;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_req.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_base(input logic [FRAME_W-1:0] b);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    sb.set_base(b);
    base_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int pick;
    repeat (n) begin
      if (send_calm > 0) begin
        send_calm--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) send_calm = $urandom_range(30, 100);
        else if (pick < 25) pause_sender($urandom_range(1, 3));
        else if (pick < 29) pause_sender($urandom_range(10, 30));
      end
      send_item(req_t'('0), 1'b1);
    end
  endtask

  initial begin : result_sink
    int stall;
    int calm;
    int pick;
    bit held;
    out_rsp.ready = 1'b0;
    stall = 0;
    calm = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted >= 300) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_rsp.ready <= 1'b0;
      end else if (calm > 0) begin
        calm--;
        out_rsp.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          calm = $urandom_range(30, 120);
          out_rsp.ready <= 1'b1;
        end else if (pick < 26) begin
          stall = $urandom_range(0, 2);
          out_rsp.ready <= 1'b0;
        end else if (pick < 30) begin
          stall = $urandom_range(10, 30);
          out_rsp.ready <= 1'b0;
        end else begin
          out_rsp.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("page_table_map_unmap_walker_unit test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.opcode = OP_MAP;
    in_req.virt_addr = '0;
    in_req.phys_addr = '0;
    in_req.flag_bits = '0;
    accepted = 0;
    base_writes = 0;
    send_calm = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // The top base value makes the first new table wrap around to frame zero.
    write_base(BASE_MAX);
    send_item(mk_req(OP_UNMAP, 48'h0, 52'h0, 12'h0), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0, '1, '1), 1'b0);
    send_item(mk_req(OP_MAP, '1, 52'h0, 12'h0), 1'b0);
    send_item(mk_req(OP_UNMAP, '1, '1, '1), 1'b0);
    send_item(mk_req(OP_UNMAP, '1, 52'h0, 12'h0), 1'b0);
    send_item(mk_req(OP_UNMAP, 48'h1000, 52'h0, 12'h0), 1'b0);
    send_item(mk_req(OP_UNMAP, 48'h20_0000, 52'h0, 12'h0), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0, 52'h1_2345_6789_0ABC, 12'h5A5), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0080_0000_0000, 52'hA_5A5A_5A5A_5000, 12'h0), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0000_4000_0000, 52'h5_A5A5_A5A5_A000, 12'h3), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0000_8000_0000, 52'hF_0000_0000_F000, 12'h800), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0100_0000_0000, 52'h1000, 12'h1), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0100_0000_0000, 52'h2000, 12'h2), 1'b0);
    send_item(mk_req(OP_UNMAP, 48'h0100_0000_0000, 52'h0, 12'h0), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0180_0000_0000, 52'h3000, 12'h4), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0000_4020_0000, 52'h4000, 12'h8), 1'b0);
    send_item(mk_req(OP_MAP, 48'h0000_4000_1000, 52'h7_FFFF_FFFF_F000, 12'hFFE), 1'b0);
    send_item(mk_req(OP_UNMAP, 48'h0000_4000_0FFF, 52'h0, 12'h0), 1'b0);
    run_random(190);
    drain();

    write_base('0);
    run_random(100);
    drain();

    // Old links now point outside the store.
    write_base(FRAME_W'({$urandom(), $urandom()}));
    send_item(mk_req(OP_MAP, 48'h0, 52'h1000, 12'h1), 1'b0);
    send_item(mk_req(OP_UNMAP, 48'h0, 52'h0, 12'h0), 1'b0);
    run_random(60);
    drain();

    write_base(40'd1);
    run_random(80);
    drain();

    write_base(BASE_MAX);
    run_random(100);
    drain();

    repeat (30) @(posedge clk);
    $display("Ran %0d requests under %0d table base settings, with exhaustion and aliasing.",
             accepted, base_writes);
    $display("Results: %0d done, %0d out of table pages, %0d no mapping; %0d mismatches.",
             sb.status_seen[ST_DONE], sb.status_seen[ST_NO_PAGES], sb.status_seen[ST_NO_MAP],
             sb.errors);
    if (sb.errors == 0) begin
      $display("page_table_map_unmap_walker_unit test passed");
    end else begin
      $display("page_table_map_unmap_walker_unit test failed");
    end
    $finish;
  end
endmodule
